@@ src/nsig_pkg.sv @@
// ============================================================================
// nsig_pkg: shared types and constants for the noise sigma estimator
// Frame geometry limits, field widths, fixed-point constants, state
// encodings for the top level and math unit, and the geometry clamp.
// ============================================================================
`default_nettype none

package nsig_pkg;

  // Geometry and pixel format
  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PIXEL_BITS   = 8;
  localparam int GEO_BITS     = 13;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [GEO_BITS-1:0]     RESET_WIDTH      = 13'd640;
  localparam logic [GEO_BITS-1:0]     RESET_HEIGHT     = 13'd480;

  // Mask response: positive and negative halves each fit in PIXEL_BITS+3
  localparam int RESP_BITS = PIXEL_BITS + 3;

  // Result widths
  localparam int SUM_BITS   = 36;
  localparam int SIGMA_BITS = 26;

  // sqrt(pi/2) as unsigned Q32
  localparam int K_BITS = 33;
  localparam logic [K_BITS-1:0] SQRT_HALF_PI_Q32 = 33'd5382943231;

  // Math unit widths
  localparam int HALF_BITS = SUM_BITS / 2;
  localparam int PART_BITS = (SUM_BITS - HALF_BITS) + K_BITS;
  localparam int NUM_BITS  = SUM_BITS + K_BITS;
  localparam int FRAC_BITS = 16;
  localparam int NSH_BITS  = NUM_BITS - FRAC_BITS;
  localparam int DEN_BITS  = COL_BITS + ROW_BITS + 3;
  localparam int CNT_BITS  = $clog2(SIGMA_BITS);

  // Top level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_MATH
  } top_state_t;

  // Math unit phases
  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL_LO,
    M_MUL_HI,
    M_SUM,
    M_CHECK,
    M_DIV,
    M_DONE
  } math_phase_t;

  // Clamp a geometry register: zero counts as one, large values saturate
  function automatic logic [GEO_BITS-1:0] geo_limit(input logic [GEO_BITS-1:0] value,
                                                    input logic [GEO_BITS-1:0] limit);
    logic [GEO_BITS-1:0] res;
    if (value == '0) begin
      res = GEO_BITS'(1);
    end else if (value > limit) begin
      res = limit;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ src/nsig_ram.sv @@
// ============================================================================
// nsig_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module nsig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/nsig_math.sv @@
// ============================================================================
// nsig_math: end-of-frame sigma computation
// sigma = floor(sum * K / (6*(w-2)*(h-2) * 2^16)), saturated to 26 bits.
// Two 18x33 partial products, then a restoring divide, one bit per cycle.
// ============================================================================
`default_nettype none

module nsig_math (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           undersized,
  input  logic [nsig_pkg::SUM_BITS-1:0]  sum,
  input  logic [nsig_pkg::COL_BITS-1:0]  w_m2,
  input  logic [nsig_pkg::ROW_BITS-1:0]  h_m2,
  input  logic                           take,
  output logic                           done,
  output logic [nsig_pkg::SIGMA_BITS-1:0] sigma
);
  import nsig_pkg::*;

  math_phase_t phase, phase_next;

  logic [SUM_BITS-1:0]          sum_q;
  logic [COL_BITS-1:0]          wm2;
  logic [ROW_BITS-1:0]          hm2;
  logic [PART_BITS-1:0]         prod;
  logic [COL_BITS+ROW_BITS-1:0] dprod;
  logic [NUM_BITS-1:0]          num;
  logic [DEN_BITS-1:0]          den;
  logic [DEN_BITS-1:0]          rem;
  logic [SIGMA_BITS-1:0]        dvd;
  logic [CNT_BITS-1:0]          cnt;

  logic [NSH_BITS-1:0] nshift;
  logic                sat;
  logic [DEN_BITS:0]   trial;
  logic                ge;
  logic [DEN_BITS:0]   diff;

  // Scaled numerator, overflow check and one restoring divide step
  always_comb begin
    nshift = num[NUM_BITS-1:FRAC_BITS];
    sat    = {1'b0, nshift} >= (NSH_BITS+1)'({den, {SIGMA_BITS{1'b0}}});
    trial  = {rem, dvd[SIGMA_BITS-1]};
    ge     = trial >= {1'b0, den};
    diff   = trial - {1'b0, den};
  end

  assign done = (phase == M_DONE);

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= M_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      M_IDLE: begin
        if (start) begin
          phase_next = undersized ? M_DONE : M_MUL_LO;
        end
      end
      M_MUL_LO: phase_next = M_MUL_HI;
      M_MUL_HI: phase_next = M_SUM;
      M_SUM:    phase_next = M_CHECK;
      M_CHECK:  phase_next = sat ? M_DONE : M_DIV;
      M_DIV: begin
        if (cnt == CNT_BITS'(SIGMA_BITS - 1)) begin
          phase_next = M_DONE;
        end
      end
      M_DONE: begin
        if (take) begin
          phase_next = M_IDLE;
        end
      end
      default: phase_next = M_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (phase)
      M_IDLE: begin
        if (start) begin
          sum_q <= sum;
          wm2   <= w_m2;
          hm2   <= h_m2;
          sigma <= '0;
        end
      end
      M_MUL_LO: begin
        prod  <= PART_BITS'(sum_q[HALF_BITS-1:0]) * PART_BITS'(SQRT_HALF_PI_Q32);
        dprod <= (COL_BITS+ROW_BITS)'(wm2) * (COL_BITS+ROW_BITS)'(hm2);
      end
      M_MUL_HI: begin
        num  <= NUM_BITS'(prod);
        prod <= PART_BITS'(sum_q[SUM_BITS-1:HALF_BITS]) * PART_BITS'(SQRT_HALF_PI_Q32);
        den  <= (DEN_BITS'(dprod) << 2) + (DEN_BITS'(dprod) << 1);
      end
      M_SUM: begin
        num <= num + (NUM_BITS'(prod) << HALF_BITS);
      end
      M_CHECK: begin
        if (sat) begin
          sigma <= '1;
        end else begin
          rem <= DEN_BITS'(nshift >> SIGMA_BITS);
          dvd <= nshift[SIGMA_BITS-1:0];
          cnt <= '0;
        end
      end
      M_DIV: begin
        rem <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        dvd <= {dvd[SIGMA_BITS-2:0], ge};
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(SIGMA_BITS - 1)) begin
          sigma <= {dvd[SIGMA_BITS-2:0], ge};
        end
      end
      M_DONE: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // Partial remainder always stays below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (phase == M_DIV) |-> (rem < den))
    else $error("nsig_math: remainder not below divisor");

  // A new frame only starts the unit when it is free
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (phase == M_IDLE))
    else $error("nsig_math: start while busy");

  // Divisor is nonzero whenever the quotient is formed
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == M_CHECK) |-> (den != '0))
    else $error("nsig_math: zero divisor");
`endif

endmodule

`default_nettype wire

@@ src/image_noise_sigma_estimator.sv @@
// ============================================================================
// image_noise_sigma_estimator: fast noise sigma estimate of a grayscale frame
// Usage:
//   Pixels enter in raster order on pixel/pixel_valid/pixel_stall, one item
//   per handshake. Frame size comes from frame_width (index 0) and
//   frame_height (index 1) on the cfg_we/cfg_index/cfg_data write port;
//   write them only between items.
//   The line store read issued at acceptance of a pixel returns the next
//   cycle, when the 3x3 mask response is accumulated and both line stores
//   are written back. No new pixel is taken until then, as the line store
//   RAMs have a registered read.
//   After the last pixel of a frame one result item (sigma in Q16.16 and
//   the raw absolute response sum) is formed by two partial-product
//   multiplies, a sum, a range check and a restoring divide. No pixel is
//   taken during that time.
//   A pending result is held in an output register; pixels keep flowing
//   while result_stall is high, but the next frame's result waits for it.
//   Reset sets the geometry to 640x480 and the position to the frame start.
//   Line stores are not cleared; each entry is written before it is used.
// ============================================================================
`default_nettype none

module image_noise_sigma_estimator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [nsig_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [nsig_pkg::GEO_BITS-1:0]       cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [nsig_pkg::PIXEL_BITS-1:0]     pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [nsig_pkg::SIGMA_BITS-1:0]     noise_sigma_q16,
  output logic [nsig_pkg::SUM_BITS-1:0]       abs_response_sum
);
  import nsig_pkg::*;

  top_state_t state, state_next;

  logic [GEO_BITS-1:0]   frame_width;
  logic [GEO_BITS-1:0]   frame_height;
  logic [COL_BITS-1:0]   col;
  logic [ROW_BITS-1:0]   row;
  logic [SUM_BITS-1:0]   acc;
  logic [SUM_BITS-1:0]   frame_sum;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [PIXEL_BITS-1:0] win [6];

  logic [PIXEL_BITS-1:0] top_px;
  logic [PIXEL_BITS-1:0] mid_px;

  logic [GEO_BITS-1:0] w_eff;
  logic [GEO_BITS-1:0] h_eff;
  logic                accept;
  logic                col_wrap;
  logic [COL_BITS-1:0] col_acc;
  logic [GEO_BITS-1:0] row_step;
  logic                row_wrap;
  logic [ROW_BITS-1:0] row_acc;

  logic [RESP_BITS-1:0] pos_sum;
  logic [RESP_BITS-1:0] neg_sum;
  logic [RESP_BITS-1:0] abs_resp;
  logic                 interior;
  logic [SUM_BITS:0]    acc_sum;
  logic [SUM_BITS-1:0]  acc_new;
  logic [GEO_BITS-1:0]  col_inc;
  logic [GEO_BITS-1:0]  row_inc;
  logic                 end_row;
  logic                 end_frame;
  logic                 undersized;

  logic                  math_start;
  logic                  math_take;
  logic                  math_done;
  logic [SIGMA_BITS-1:0] math_sigma;
  logic                  load_result;

  // Effective geometry
  assign w_eff = geo_limit(frame_width, GEO_BITS'(MAX_WIDTH));
  assign h_eff = geo_limit(frame_height, GEO_BITS'(HEIGHT_LIMIT));
  assign undersized = (w_eff < GEO_BITS'(3)) || (h_eff < GEO_BITS'(3));

  // Position of the incoming pixel; wraps if the geometry shrank
  always_comb begin
    accept   = pixel_valid && !pixel_stall;
    col_wrap = GEO_BITS'(col) >= w_eff;
    col_acc  = col_wrap ? '0 : col;
    row_step = GEO_BITS'(row) + GEO_BITS'(col_wrap);
    row_wrap = row_step >= h_eff;
    row_acc  = row_wrap ? '0 : row_step[ROW_BITS-1:0];
  end

  // Line stores: a holds the previous row, b the row before it
  nsig_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (state == S_CALC),
    .waddr (col),
    .wdata (pix_q),
    .re    (accept),
    .raddr (col_acc),
    .rdata (mid_px)
  );

  nsig_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (state == S_CALC),
    .waddr (col),
    .wdata (mid_px),
    .re    (accept),
    .raddr (col_acc),
    .rdata (top_px)
  );

  // Mask response, split into positive and negative taps
  always_comb begin
    pos_sum = RESP_BITS'(win[0]) + RESP_BITS'(win[2]) + RESP_BITS'(top_px)
            + RESP_BITS'(pix_q) + (RESP_BITS'(win[4]) << 2);
    neg_sum = (RESP_BITS'(win[1]) + RESP_BITS'(win[3]) + RESP_BITS'(mid_px)
            + RESP_BITS'(win[5])) << 1;
    abs_resp = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
    interior = (row >= ROW_BITS'(2)) && (col >= COL_BITS'(2));
    acc_sum  = {1'b0, acc} + (SUM_BITS+1)'(abs_resp);
    if (!interior) begin
      acc_new = acc;
    end else if (acc_sum[SUM_BITS]) begin
      acc_new = '1;
    end else begin
      acc_new = acc_sum[SUM_BITS-1:0];
    end
    col_inc   = GEO_BITS'(col) + GEO_BITS'(1);
    row_inc   = GEO_BITS'(row) + GEO_BITS'(1);
    end_row   = col_inc >= w_eff;
    end_frame = end_row && (row_inc >= h_eff);
  end

  // Sigma computation
  nsig_math u_math (
    .clk        (clk),
    .rst        (rst),
    .start      (math_start),
    .undersized (undersized),
    .sum        (acc_new),
    .w_m2       (COL_BITS'(w_eff - GEO_BITS'(2))),
    .h_m2       (ROW_BITS'(h_eff - GEO_BITS'(2))),
    .take       (math_take),
    .done       (math_done),
    .sigma      (math_sigma)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake controls
  always_comb begin
    state_next  = state;
    pixel_stall = 1'b1;
    math_start  = 1'b0;
    math_take   = 1'b0;
    load_result = 1'b0;
    unique case (state)
      S_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (end_frame) begin
          math_start = 1'b1;
          state_next = S_MATH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MATH: begin
        if (math_done && !(result_valid && result_stall)) begin
          math_take   = 1'b1;
          load_result = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // Position, window and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      acc <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (accept) begin
      col   <= col_acc;
      row   <= row_acc;
      pix_q <= pixel;
      if (row_wrap) begin
        acc <= '0;
      end
    end else if (state == S_CALC) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_px;
      win[4] <= mid_px;
      win[5] <= pix_q;
      if (end_frame) begin
        col       <= '0;
        row       <= '0;
        acc       <= '0;
        frame_sum <= undersized ? '0 : acc_new;
      end else if (end_row) begin
        col <= '0;
        row <= row_inc[ROW_BITS-1:0];
        acc <= acc_new;
      end else begin
        col <= col_inc[COL_BITS-1:0];
        acc <= acc_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      noise_sigma_q16  <= math_sigma;
      abs_response_sum <= frame_sum;
    end
  end

`ifndef SYNTHESIS
  // An accepted pixel is processed in the following cycle
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> (state == S_CALC))
    else $error("top: accepted pixel not processed");

  // A result only appears out of the frame-end computation
  a_result_from_math: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_MATH))
    else $error("top: result without frame end");

  // While the frame-end math runs, the next frame starts from scratch
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (state == S_MATH) |-> ((col == '0) && (row == '0) && (acc == '0)))
    else $error("top: position not cleared at frame end");
`endif

endmodule

`default_nettype wire

@@ dv/tb_image_noise_sigma_estimator.sv @@
// ============================================================================
// tb_image_noise_sigma_estimator: self-checking bench for the noise sigma
// estimator
// Streams whole frames of pixels through the block under several frame
// geometries and idle patterns. A built-in mask model tracks the line stores
// and the 3x3 window, predicts the absolute response sum and the Q16.16 sigma
// of each frame, and checks every result item against it field by field.
// ============================================================================
`default_nettype none

module tb_image_noise_sigma_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import nsig_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PIXELS = 600;

  typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;
  typedef enum {FRAME_RANDOM, FRAME_FLAT_NOISY} frame_style_t;

  typedef struct {
    bit [SIGMA_BITS-1:0] sigma;
    bit [SUM_BITS-1:0]   sum;
  } frame_result_t;

  // Mask model of the estimator plus the queue of frame results still owed
  class noise_sigma_tracker;
    bit [GEO_BITS-1:0]   width_reg;
    bit [GEO_BITS-1:0]   height_reg;
    bit [PIXEL_BITS-1:0] row_above [MAX_WIDTH];
    bit [PIXEL_BITS-1:0] row_two_above [MAX_WIDTH];
    bit [PIXEL_BITS-1:0] left_col [3];
    bit [PIXEL_BITS-1:0] center_col [3];
    int                  col;
    int                  row;
    bit [SUM_BITS-1:0]   acc;
    frame_result_t       expected_frames [$];
    int                  mismatches;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
    endfunction

    function void write_register(bit [CFG_IDX_BITS-1:0] index, bit [GEO_BITS-1:0] value);
      if (index == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else if (index == REG_FRAME_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    // Zero counts as one, oversize saturates
    function int active_width();
      if (width_reg == 0) return 1;
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function int active_height();
      if (height_reg == 0) return 1;
      return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
    endfunction

    // Advance the window by one accepted pixel; queue a result at frame end
    function void accept_pixel(bit [PIXEL_BITS-1:0] value);
      int              w, h, c, r, top, mid, resp;
      longint          denom;
      bit [SUM_BITS:0] widened;
      bit [71:0]       product, quotient;
      frame_result_t   res;
      w = active_width();
      h = active_height();
      c = col;
      r = row;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) begin
        r = 0;
        acc = '0;
      end
      top = row_two_above[c];
      mid = row_above[c];

      // mask [1 -2 1; -2 4 -2; 1 -2 1] at interior positions
      if (r >= 2 && c >= 2) begin
        resp = int'(left_col[0]) - 2 * int'(center_col[0]) + top
             - 2 * int'(left_col[1]) + 4 * int'(center_col[1]) - 2 * mid
             + int'(left_col[2]) - 2 * int'(center_col[2]) + int'(value);
        if (resp < 0) resp = -resp;
        widened = {1'b0, acc} + (SUM_BITS+1)'(resp);
        acc = widened[SUM_BITS] ? '1 : widened[SUM_BITS-1:0];
      end

      left_col   = center_col;
      center_col = '{top[PIXEL_BITS-1:0], mid[PIXEL_BITS-1:0], value};
      row_two_above[c] = mid[PIXEL_BITS-1:0];
      row_above[c]     = value;

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          res.sigma = '0;
          res.sum   = '0;
          if (w >= 3 && h >= 3) begin
            denom    = 6 * longint'(w - 2) * longint'(h - 2);
            product  = 72'(acc) * 72'(SQRT_HALF_PI_Q32);
            quotient = product / (72'(denom) << 16);
            res.sum  = acc;
            if (quotient >= (72'(1) << SIGMA_BITS)) begin
              res.sigma = '1;
            end else begin
              res.sigma = quotient[SIGMA_BITS-1:0];
            end
          end
          expected_frames.push_back(res);
          col = 0;
          row = 0;
          acc = '0;
          return;
        end
      end
      col = c;
      row = r;
    endfunction

    function void check_result(bit [SIGMA_BITS-1:0] sigma, bit [SUM_BITS-1:0] sum);
      frame_result_t exp_res;
      if (expected_frames.size() == 0) begin
        $error("result item with no frame pending: sigma %0d sum %0d", sigma, sum);
        mismatches++;
        return;
      end
      exp_res = expected_frames.pop_front();
      if (sigma !== exp_res.sigma) begin
        $error("noise_sigma_q16: expected %0d, got %0d", exp_res.sigma, sigma);
        mismatches++;
      end
      if (sum !== exp_res.sum) begin
        $error("abs_response_sum: expected %0d, got %0d", exp_res.sum, sum);
        mismatches++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [GEO_BITS-1:0]     cfg_data;
  logic                    pixel_valid;
  logic                    pixel_stall;
  logic [PIXEL_BITS-1:0]   pixel;
  logic                    result_valid;
  logic                    result_stall;
  logic [SIGMA_BITS-1:0]   noise_sigma_q16;
  logic [SUM_BITS-1:0]     abs_response_sum;

  noise_sigma_tracker tracker = new();
  idle_mode_t         idle_mode = IDLE_NONE;
  bit                 hold_request = 1'b0;
  int                 cycle_count;

  image_noise_sigma_estimator uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pixel_valid      (pixel_valid),
    .pixel_stall      (pixel_stall),
    .pixel            (pixel),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .noise_sigma_q16  (noise_sigma_q16),
    .abs_response_sum (abs_response_sum)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: check accepted items, stall at random or for a long hold
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    result_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && result_stall === 1'b0) begin
        tracker.check_result(noise_sigma_q16, abs_response_sum);
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < ((idle_mode == IDLE_SINK) ? 64 :
                                               (idle_mode == IDLE_BOTH) ? 15 : 0));
      end
    end
  end

  // Offer one pixel item, with random idle cycles ahead of it
  task automatic send_pixel(input bit [PIXEL_BITS-1:0] value);
    while ($urandom_range(99) < ((idle_mode == IDLE_SOURCE) ? 64 :
                                 (idle_mode == IDLE_BOTH) ? 15 : 0)) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= value;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    tracker.accept_pixel(value);
  endtask

  task automatic send_frame(input frame_style_t style);
    int npix, base, v;
    npix = tracker.active_width() * tracker.active_height();
    base = $urandom_range(255);
    for (int i = 0; i < npix; i++) begin
      if (style == FRAME_RANDOM) begin
        v = $urandom_range(255);
      end else begin
        v = base + int'($urandom_range(8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      send_pixel(PIXEL_BITS'(v));
    end
  endtask

  // Drain: all results in, then let the math unit go quiet
  task automatic settle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input bit [GEO_BITS-1:0] w, input bit [GEO_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_register(REG_FRAME_WIDTH, w);
    tracker.write_register(REG_FRAME_HEIGHT, h);
  endtask

  // Main sequence
  initial begin
    int w, h, frames, random_pixels, phase_no;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_FRAME_WIDTH;
    cfg_data    <= '0;
    pixel_valid <= 1'b0;
    pixel       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed: smallest full frame, flat and maximum-response checkerboard
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++) send_pixel('0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) send_pixel(((r + c) % 2 == 0) ? 8'hFF : 8'h00);
    end
    // zero geometry counts as a 1x1 frame
    settle();
    set_geometry(0, 0);
    send_pixel(8'hFF);
    // frame too small for any interior pixel
    settle();
    set_geometry(2, 2);
    send_pixel(8'hAA);
    send_pixel(8'h55);
    send_pixel(8'hFF);
    send_pixel(8'h00);

    // Random geometries and content, rotating through the idle patterns
    random_pixels = 0;
    phase_no = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      settle();
      idle_mode = idle_mode_t'(phase_no % 4);
      if ($urandom_range(4) == 0) begin
        // narrow or short frame, zero sizes included
        if ($urandom_range(1) == 0) begin
          w = $urandom_range(2);
          h = $urandom_range(6);
        end else begin
          w = $urandom_range(6);
          h = $urandom_range(2);
        end
      end else begin
        w = $urandom_range(12, 3);
        h = $urandom_range(8, 3);
      end
      set_geometry(GEO_BITS'(w), GEO_BITS'(h));
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        send_frame(($urandom_range(2) == 0) ? FRAME_FLAT_NOISY : FRAME_RANDOM);
      end
      random_pixels += frames * tracker.active_width() * tracker.active_height();
      phase_no++;
    end

    // Back-pressure: result side holds off while frames keep coming
    settle();
    idle_mode = IDLE_NONE;
    set_geometry(3, 3);
    hold_request = 1'b1;
    for (int f = 0; f < 10; f++) send_frame(FRAME_RANDOM);

    // Wrap up
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_frames.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ image_noise_sigma_estimator.f @@
src/nsig_pkg.sv
src/nsig_ram.sv
src/nsig_math.sv
src/image_noise_sigma_estimator.sv
dv/tb_image_noise_sigma_estimator.sv
